### design/key_short_long_press_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key press detector
// Concurrent checks, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define KSLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kslp assertion failed");
// next-cycle implication
`define KSLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kslp assertion failed");
`else
`define KSLP_ASSERT_NOW(label, ante, cons)
`define KSLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/kslp_pkg.sv
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and constants for the key short/long press detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kslp_pkg;

    localparam int NUM_KEYS_DEF  = 4;
    localparam int KEY_LEVELS_W  = 4;

    localparam logic [31:0] DEBOUNCE_RESET = 32'd20;
    localparam logic [31:0] LONG_RESET     = 32'd1000;

    // configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_LONG     = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [31:0] timestamp;
        logic [KEY_LEVELS_W-1:0] key_levels;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] key_index;
    } out_word_t;

    typedef struct packed {
        logic [31:0] debounce_ticks;
        logic [31:0] long_press_ticks;
    } cfg_t;

endpackage

### design/kslp_lane.sv
// ----------------------------------------------------------------------------
// kslp_lane
// Per-key state and edge/duration logic; reports the event this key would
// raise for the current scan and commits its state when enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kslp_lane
    import kslp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic [31:0] now,
    input  logic        lvl,
    input  logic        upd_en,
    output ev_kind_t    kind
);

    logic        prev_level_reg,  prev_level_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        long_fired_reg,  long_fired_next;
    logic [31:0] held;

    assign held = now - press_start_reg;

    always_comb begin
        prev_level_next  = prev_level_reg;
        press_start_next = press_start_reg;
        long_fired_next  = long_fired_reg;
        kind             = EV_NONE;
        if (lvl != prev_level_reg) begin
            prev_level_next = lvl;
            if (!lvl) begin
                press_start_next = now;
                long_fired_next  = 1'b0;
                // duration is zero right at the press
                if (cfg.long_press_ticks == 32'd0) begin
                    kind            = EV_LONG;
                    long_fired_next = 1'b1;
                end
            end else if (!long_fired_reg && held >= cfg.debounce_ticks &&
                         held < cfg.long_press_ticks) begin
                kind = EV_SHORT;
            end
        end else if (!lvl && !long_fired_reg && held >= cfg.long_press_ticks) begin
            kind            = EV_LONG;
            long_fired_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg  <= 1'b1;
            press_start_reg <= '0;
            long_fired_reg  <= 1'b0;
        end else if (upd_en) begin
            prev_level_reg  <= prev_level_next;
            press_start_reg <= press_start_next;
            long_fired_reg  <= long_fired_next;
        end
    end

endmodule

### design/kslp_merge.sv
// ----------------------------------------------------------------------------
// kslp_merge
// Priority merge of lane events: lowest reporting key wins, and only keys up
// to and including the winner commit their state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kslp_merge
    import kslp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  ev_kind_t              kinds [NUM_KEYS],
    input  logic                  accept,
    output logic [NUM_KEYS-1:0]   upd_en,
    output logic [NUM_KEYS-1:0]   fire,
    output out_word_t             result
);

    always_comb begin
        logic blocked;
        blocked           = 1'b0;
        result.event_kind = EV_NONE;
        result.key_index  = 2'd0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            fire[k]   = (kinds[k] != EV_NONE);
            upd_en[k] = accept && !blocked;
            if (fire[k] && !blocked) begin
                result.event_kind = kinds[k];
                result.key_index  = 2'(k);
            end
            blocked = blocked | fire[k];
        end
    end

endmodule

### design/key_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// key_short_long_press_detector
// Short/long press detection for a row of active-low keys.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_word carry one scan word: a 32-bit tick count and the
//   key levels (1 released, 0 pressed). Every accepted word yields exactly one
//   result word on m_valid/m_ready/m_word: event kind (none, short, long) and
//   the index of the lowest key that reported.
//   The result is registered at the accept edge, in the result register or, while
//   the receiver stalls, in the skid register, and is shown on m_*. Throughput is
//   one word per cycle while s_ready is high, set by the per-key subtract and
//   compare plus the priority merge that update key state at the accept edge.
//   A two-entry output stage (result register plus skid register) keeps
//   s_ready high for one more word while the receiver stalls; s_ready drops
//   only when both are full.
//   Thresholds are written through cfg_wr_en/cfg_addr/cfg_wdata while idle.
//   Synchronous reset (aresetn low) marks all keys released with clear press
//   times, restores the default thresholds and empties the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "key_short_long_press_detector_assert.svh"

module key_short_long_press_detector
    import kslp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word
);

    cfg_t                cfg_reg;
    ev_kind_t            kinds [NUM_KEYS];
    logic [NUM_KEYS-1:0] levels;
    logic [NUM_KEYS-1:0] upd_en;
    logic [NUM_KEYS-1:0] fire;
    out_word_t           result;
    logic                accept;
    logic                load;

    out_word_t out_word_reg, skid_word_reg;
    logic      out_valid_reg, skid_valid_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_wdata;
                CFG_LONG:     cfg_reg.long_press_ticks <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // keys past the input width read as pressed
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        if (k < KEY_LEVELS_W) begin : g_in
            assign levels[k] = s_word.key_levels[k];
        end else begin : g_pad
            assign levels[k] = 1'b0;
        end

        kslp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .now     (s_word.timestamp),
            .lvl     (levels[k]),
            .upd_en  (upd_en[k]),
            .kind    (kinds[k])
        );
    end

    kslp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .kinds  (kinds),
        .accept (accept),
        .upd_en (upd_en),
        .fire   (fire),
        .result (result)
    );

    // output register with skid word
    assign load = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : result;
        end
        if (!load && accept) begin
            skid_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    `KSLP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `KSLP_ASSERT_NEXT(a_stall_to_skid, accept && m_valid && !m_ready, skid_valid_reg)
    `KSLP_ASSERT_NOW(a_one_winner, 1'b1, $onehot0(fire & upd_en & ~(upd_en >> 1)))
    `KSLP_ASSERT_NOW(a_none_index_zero, m_valid && m_word.event_kind == EV_NONE, m_word.key_index == 2'd0)

endmodule
